// ===== src/vic_pkg.sv =====
// Package for the vectored interrupt controller: item types, codes, register
// offsets and the id byte table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vic_pkg;

  localparam int SOURCES_DEF = 32;
  localparam int LEVELS_DEF  = 16;
  localparam int STACK_DEPTH = 17;

  localparam logic [5:0] DAISY_CODE = 6'd32;
  localparam logic [5:0] NONE_CODE  = 6'd33;
  localparam logic [4:0] STACK_TOP  = 5'd16;

  // commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LINE  = 2'd2;
  localparam logic [1:0] CMD_DAISY = 2'd3;

  // register offsets
  localparam logic [11:0] OFF_IRQSTATUS = 12'h000;
  localparam logic [11:0] OFF_FIQSTATUS = 12'h004;
  localparam logic [11:0] OFF_RAWINTR   = 12'h008;
  localparam logic [11:0] OFF_INTSELECT = 12'h00C;
  localparam logic [11:0] OFF_INTENABLE = 12'h010;
  localparam logic [11:0] OFF_INTENCLR  = 12'h014;
  localparam logic [11:0] OFF_SOFTINT   = 12'h018;
  localparam logic [11:0] OFF_SOFTCLR   = 12'h01C;
  localparam logic [11:0] OFF_PROTECT   = 12'h020;
  localparam logic [11:0] OFF_SWPRIMASK = 12'h024;
  localparam logic [11:0] OFF_PRIDAISY  = 12'h028;
  localparam logic [11:0] OFF_LEGACY0   = 12'h030;
  localparam logic [11:0] OFF_LEGACY1   = 12'h034;
  localparam logic [11:0] OFF_LEGACY2   = 12'h300;
  localparam logic [11:0] OFF_VECTADDR  = 12'hF00;
  localparam logic [11:0] OFF_ID_BASE   = 12'hFE0;
  localparam logic [11:0] OFF_VEC_BASE  = 12'h100;
  localparam logic [11:0] OFF_PRI_BASE  = 12'h200;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] byte_offset;
    logic [31:0] write_data;
    logic [4:0]  source_index;
    logic        line_level;
    logic [31:0] daisy_vector;
  } vic_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic        fiq_line;
    logic        daisy_acknowledge;
    logic        daisy_finish;
    logic        bus_error;
  } vic_out_t;

  // candidate carried along the cell chain
  typedef struct packed {
    logic [5:0] code;
    logic [4:0] level;
  } vic_cand_t;

  function automatic logic [7:0] id_byte(input logic [2:0] i);
    case (i)
      3'd0:    id_byte = 8'h92;
      3'd1:    id_byte = 8'h11;
      3'd2:    id_byte = 8'h04;
      3'd3:    id_byte = 8'h00;
      3'd4:    id_byte = 8'h0D;
      3'd5:    id_byte = 8'hF0;
      3'd6:    id_byte = 8'h05;
      3'd7:    id_byte = 8'hB1;
      default: id_byte = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== src/vic_cell.sv =====
// One priority cell: compares its source against the candidate passed in and
// hands the better one on. Depends on vic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vic_cell
  import vic_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF
) (
  input  wire logic       clk,
  input  wire logic       load,
  input  wire logic       req,
  input  wire logic [5:0] my_code,
  input  wire logic [3:0] my_pri,
  input  wire logic [15:0] lvl_en,
  input  wire vic_cand_t  cand_in,
  output vic_cand_t       cand_out
);
  vic_cand_t cand_r, cand_nxt;
  logic      ok;

  // eligible when requesting, priority in range and level enabled
  always_comb begin
    ok = req && ({1'b0, my_pri} < 5'(LEVELS)) && lvl_en[my_pri];
    cand_nxt = cand_in;
    // strict compare: earlier cells (lower index) win ties
    if (ok && ({1'b0, my_pri} < cand_in.level)) begin
      cand_nxt.code  = my_code;
      cand_nxt.level = {1'b0, my_pri};
    end
  end

  always_ff @(posedge clk) begin
    if (load) cand_r <= cand_nxt;
  end

  assign cand_out = cand_r;
endmodule
`default_nettype wire

// ===== src/vic_chain.sv =====
// Row of priority cells over all sources plus the daisy request; the best
// candidate ripples one cell per cycle while load is high.
// Depends on vic_pkg and vic_cell.
`timescale 1ns / 1ps
`default_nettype none
module vic_chain
  import vic_pkg::*;
#(
  parameter int SOURCES = SOURCES_DEF,
  parameter int LEVELS  = LEVELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic [31:0]       irqs,
  input  wire logic [4*32-1:0]   pri_flat,
  input  wire logic              daisy_req,
  input  wire logic [3:0]        daisy_pri,
  input  wire logic [15:0]       lvl_en,
  output vic_cand_t              best
);
  vic_cand_t link [0:SOURCES+1];

  assign link[0] = '{code: NONE_CODE, level: 5'd16};

  for (genvar g = 0; g < SOURCES; g++) begin : g_cell
    vic_cell #(.LEVELS(LEVELS)) u_cell (
      .clk(clk), .load(load), .req(irqs[g]), .my_code(6'(g)),
      .my_pri(pri_flat[4*g +: 4]), .lvl_en(lvl_en),
      .cand_in(link[g]), .cand_out(link[g+1]));
  end

  // daisy comes last among equals
  vic_cell #(.LEVELS(LEVELS)) u_daisy (
    .clk(clk), .load(load), .req(daisy_req), .my_code(DAISY_CODE),
    .my_pri(daisy_pri), .lvl_en(lvl_en),
    .cand_in(link[SOURCES]), .cand_out(link[SOURCES+1]));

  assign best = link[SOURCES+1];
endmodule
`default_nettype wire

// ===== src/vectored_interrupt_controller.sv =====
// Vectored interrupt controller top level: register file, nesting stack,
// sequencer and result register. Depends on vic_pkg and vic_chain.
//
// Each item (bus read, bus write, line change or daisy change) is handled one
// at a time. A bus access or event is applied in the EXEC state, then the
// priority chain re-resolves the best pending request by letting the candidate
// ripple through its registered cells, one cell per cycle, in the RUN state;
// the UPD state settles IRQ and the OUT state loads the output register.
// Acknowledge and finish take the same single pass. A new item is not taken
// until the last one has left the OUT state; a result stalled at the output
// holds the next item only when that item's own result is ready.
`timescale 1ns / 1ps
`default_nettype none
module vectored_interrupt_controller
  import vic_pkg::*;
#(
  parameter int SOURCES = SOURCES_DEF,
  parameter int LEVELS  = LEVELS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire vic_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output vic_out_t     out_data
);
  localparam int CW = $clog2(SOURCES + 3);
  localparam logic [31:0] SRC_MASK = (SOURCES == 32) ? 32'hFFFF_FFFF
                                     : 32'((64'd1 << SOURCES) - 64'd1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  vic_in_t     item_r;

  logic [31:0] raw_r, en_r, fsel_r, soft_r;
  logic        prot_r;
  logic [15:0] lvlen_r;
  logic [3:0]  dpri_r;
  logic [31:0] vtab_r [0:31];
  logic [3:0]  spri_r [0:31];
  logic        dpend_r;
  logic [31:0] daddr_r;
  logic [5:0]  act_src_r, best_r;
  logic [31:0] selvec_r;
  logic [4:0]  depth_r;
  logic [4:0]  lstk_r [0:STACK_DEPTH-1];
  logic [5:0]  sstk_r [0:STACK_DEPTH-1];
  logic [4:0]  act_lvl_r;
  logic        irq_r;

  vic_out_t    wrk_r;        // result being built
  vic_out_t    res_r;
  logic        out_valid_r;

  logic [31:0] act_lines, irqs;
  logic [4*32-1:0] pri_flat;
  vic_cand_t   chain_best;

  assign act_lines = (raw_r | soft_r) & en_r & SRC_MASK;
  assign irqs      = act_lines & ~fsel_r;

  always_comb begin
    for (int i = 0; i < 32; i++) pri_flat[4*i +: 4] = spri_r[i];
  end

  vic_chain #(.SOURCES(SOURCES), .LEVELS(LEVELS)) u_chain (
    .clk(clk), .load(state_r == ST_RUN), .irqs(irqs), .pri_flat(pri_flat),
    .daisy_req(dpend_r), .daisy_pri(dpri_r), .lvl_en(lvlen_r), .best(chain_best));

  // offset decode
  logic [11:0] off;
  logic        misal, in_vec, in_pri, vidx_ok, pidx_ok;
  logic [4:0]  vidx, pidx;
  always_comb begin
    off     = item_r.byte_offset;
    misal   = off[1:0] != 2'd0;
    in_vec  = (off >= OFF_VEC_BASE) && (off < 12'h180);
    in_pri  = (off >= OFF_PRI_BASE) && (off < 12'h280);
    vidx    = off[6:2];
    pidx    = off[6:2];
    vidx_ok = {1'b0, vidx} < 6'(SOURCES);
    pidx_ok = {1'b0, pidx} < 6'(SOURCES);
  end

  // read mux
  logic [31:0] rd;
  logic        rd_err;
  always_comb begin
    rd = '0;
    rd_err = 1'b0;
    if (misal) rd_err = 1'b1;
    else if (off >= OFF_ID_BASE) rd = {24'd0, id_byte(off[4:2])};
    else if (in_vec) rd = vidx_ok ? vtab_r[vidx] : 32'd0;
    else if (in_pri) rd = pidx_ok ? {28'd0, spri_r[pidx]} : 32'd0;
    else begin
      case (off)
        OFF_IRQSTATUS: rd = act_lines & ~fsel_r;
        OFF_FIQSTATUS: rd = act_lines & fsel_r;
        OFF_RAWINTR:   rd = raw_r;
        OFF_INTSELECT: rd = fsel_r;
        OFF_INTENABLE: rd = en_r;
        OFF_SOFTINT:   rd = soft_r;
        OFF_PROTECT:   rd = {31'd0, prot_r};
        OFF_SWPRIMASK: rd = {16'd0, lvlen_r};
        OFF_PRIDAISY:  rd = {28'd0, dpri_r};
        OFF_VECTADDR:  rd = selvec_r;
        OFF_INTENCLR, OFF_SOFTCLR, OFF_LEGACY0, OFF_LEGACY1, OFF_LEGACY2: rd = '0;
        default:       rd_err = 1'b1;
      endcase
    end
  end

  // priority of the chain's winner
  logic [4:0] best_lvl;
  assign best_lvl = chain_best.level;

  logic [4:0] push_idx, pop_idx;
  assign push_idx = (depth_r < STACK_TOP) ? depth_r + 5'd1 : depth_r;
  assign pop_idx  = depth_r - 5'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && !in_stall) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_RUN;
      ST_RUN:  if (cnt_r == CW'(SOURCES + 1)) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      raw_r <= '0; en_r <= '0; fsel_r <= '0; soft_r <= '0;
      prot_r <= 1'b0; lvlen_r <= 16'hFFFF; dpri_r <= 4'hF;
      dpend_r <= 1'b0; daddr_r <= '0;
      act_src_r <= NONE_CODE; best_r <= NONE_CODE; selvec_r <= '0;
      depth_r <= '0; act_lvl_r <= 5'(LEVELS); irq_r <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        vtab_r[i] <= '0;
        spri_r[i] <= 4'hF;
      end
      lstk_r[0] <= 5'(LEVELS);
      sstk_r[0] <= NONE_CODE;
    end else begin
      state_r <= state_nxt;
      // output register: load when free or being taken, clear when taken
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            item_r <= in_data;
            wrk_r <= '0;
          end
        end
        ST_EXEC: begin
          cnt_r <= '0;
          case (item_r.command)
            CMD_READ: begin
              wrk_r.read_data <= rd;
              wrk_r.bus_error <= rd_err;
              if (!misal && off == OFF_VECTADDR && best_r != NONE_CODE) begin
                // acknowledge: push active level
                act_src_r <= best_r;
                depth_r <= push_idx;
                act_lvl_r <= (best_r == DAISY_CODE) ? {1'b0, dpri_r}
                                                    : {1'b0, spri_r[best_r[4:0]]};
                lstk_r[push_idx] <= (best_r == DAISY_CODE) ? {1'b0, dpri_r}
                                                           : {1'b0, spri_r[best_r[4:0]]};
                sstk_r[push_idx] <= best_r;
                wrk_r.daisy_acknowledge <= best_r == DAISY_CODE;
              end
            end
            CMD_WRITE: begin
              if (misal || off >= OFF_ID_BASE) wrk_r.bus_error <= 1'b1;
              else if (in_vec) begin
                if (vidx_ok) vtab_r[vidx] <= item_r.write_data;
              end else if (in_pri) begin
                if (pidx_ok) spri_r[pidx] <= item_r.write_data[3:0];
              end else begin
                case (off)
                  OFF_IRQSTATUS, OFF_LEGACY0, OFF_LEGACY1, OFF_LEGACY2: ;
                  OFF_FIQSTATUS, OFF_RAWINTR: wrk_r.bus_error <= 1'b1;
                  OFF_INTSELECT: fsel_r <= item_r.write_data;
                  OFF_INTENABLE: en_r <= en_r | item_r.write_data;
                  OFF_INTENCLR:  en_r <= en_r & ~item_r.write_data;
                  OFF_SOFTINT:   soft_r <= soft_r | item_r.write_data;
                  OFF_SOFTCLR:   soft_r <= soft_r & ~item_r.write_data;
                  OFF_PROTECT:   prot_r <= item_r.write_data[0];
                  OFF_SWPRIMASK: lvlen_r <= item_r.write_data[15:0];
                  OFF_PRIDAISY:  dpri_r <= item_r.write_data[3:0];
                  OFF_VECTADDR: begin
                    wrk_r.daisy_finish <= act_src_r == DAISY_CODE;
                    if (depth_r != 5'd0) begin
                      depth_r <= pop_idx;
                      act_lvl_r <= lstk_r[pop_idx];
                      act_src_r <= sstk_r[pop_idx];
                    end
                  end
                  default: wrk_r.bus_error <= 1'b1;
                endcase
              end
            end
            CMD_LINE: begin
              if ({1'b0, item_r.source_index} < 6'(SOURCES))
                raw_r[item_r.source_index] <= item_r.line_level;
            end
            default: begin
              dpend_r <= item_r.line_level;
              if (item_r.line_level) daddr_r <= item_r.daisy_vector;
            end
          endcase
        end
        ST_RUN: cnt_r <= cnt_r + CW'(1);
        ST_UPD: begin
          cnt_r <= '0;
          if (irqs != 32'd0 || dpend_r) begin
            best_r <= chain_best.code;
            selvec_r <= (chain_best.code < DAISY_CODE) ? vtab_r[chain_best.code[4:0]]
                                                       : daddr_r;
            if (chain_best.code != act_src_r) begin
              if (chain_best.code <= DAISY_CODE) begin
                if (best_lvl < act_lvl_r) irq_r <= 1'b1;
              end else irq_r <= 1'b0;
            end
          end else begin
            best_r <= NONE_CODE;
            irq_r <= 1'b0;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall)
            res_r <= {wrk_r.read_data, irq_r, (act_lines & fsel_r) != 32'd0,
                      wrk_r.daisy_acknowledge, wrk_r.daisy_finish, wrk_r.bus_error};
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/vic_checker.sv =====
// Port-level checker for the interrupt controller, bound to the top level.
// Depends on vic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vic_props
  import vic_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire vic_out_t out_data
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // acknowledge and finish come from different items
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.daisy_acknowledge && out_data.daisy_finish))
    else $error("acknowledge and finish together");

  // acknowledge only comes with no bus error
  a_ack_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.daisy_acknowledge |-> !out_data.bus_error)
    else $error("acknowledge with bus error");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind vectored_interrupt_controller vic_props u_vic_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
`default_nettype wire
